// File: design/assert_macros.svh
// assertion macros shared by the frame finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/tcff_pkg.sv
// types, constants and title tables for the titled frame finder
`timescale 1ns / 1ps

package tcff_pkg;

  // frame limits
  localparam int unsigned MAX_FRAME = 1024;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME);
  localparam int unsigned LEN_SAT   = 1023;
  localparam int unsigned LEN_W     = 10;

  // title tables
  localparam int unsigned NUM_TITLES = 6;
  localparam int unsigned WIN_MAX    = 8;
  localparam int unsigned FILL_W     = $clog2(WIN_MAX);
  localparam int unsigned TLEN_W     = $clog2(WIN_MAX + 1);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // special characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    MSG_NONE    = 3'd0,
    MSG_INITACK = 3'd1,
    MSG_PING    = 3'd2,
    MSG_PONG    = 3'd3,
    MSG_MESSAGE = 3'd4,
    MSG_CCTXA   = 3'd5,
    MSG_NOJOB   = 3'd6
  } msg_type_t;

  typedef enum logic {
    PH_HUNT = 1'b0,
    PH_BODY = 1'b1
  } phase_t;

  localparam logic [7:0] TITLE_TEXT [NUM_TITLES][WIN_MAX] = '{
    '{8'h24, 8'h69, 8'h6E, 8'h69, 8'h74, 8'h61, 8'h63, 8'h6B},  // $initack
    '{8'h24, 8'h70, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00, 8'h00},  // $ping
    '{8'h24, 8'h70, 8'h6F, 8'h6E, 8'h67, 8'h00, 8'h00, 8'h00},  // $pong
    '{8'h24, 8'h6D, 8'h65, 8'h73, 8'h73, 8'h61, 8'h67, 8'h65},  // $message
    '{8'h24, 8'h43, 8'h43, 8'h54, 8'h58, 8'h41, 8'h00, 8'h00},  // $CCTXA
    '{8'h24, 8'h4E, 8'h4F, 8'h4A, 8'h4F, 8'h42, 8'h00, 8'h00}   // $NOJOB
  };

  localparam logic [TLEN_W-1:0] TITLE_LEN [NUM_TITLES] = '{
    TLEN_W'(8), TLEN_W'(5), TLEN_W'(5), TLEN_W'(8), TLEN_W'(6), TLEN_W'(6)
  };

  localparam msg_type_t TITLE_KIND [NUM_TITLES] = '{
    MSG_INITACK, MSG_PING, MSG_PONG, MSG_MESSAGE, MSG_CCTXA, MSG_NOJOB
  };

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0]                           data;
    logic                                 is_dollar;
    logic                                 is_cr;
    logic                                 is_lf;
    logic [NUM_TITLES-1:0][WIN_MAX-1:0]   char_match;
  } class_beat_t;

endpackage

// File: design/title_crlf_frame_finder.sv
// top level of the titled, CR LF terminated frame finder
//
// Byte stream in on data_byte (in_valid / in_ready), one result beat out per
// input beat (out_valid / out_ready) carrying the echoed byte, title hit,
// body / done / overflow flags, message type, frame length and running XOR.
// A byte accepted on the input is registered first in the classify queue,
// then in the back end's output register.
// Throughput: one byte per cycle while the receiver keeps out_ready high,
// set by the back end updating its match and frame state for each byte.
// The input side keeps accepting while the output holds a result, until the
// two-entry queue fills; in_ready is simply "queue not full".
// When the receiver stalls, the output register holds its beat and the back
// end stops popping; the queue absorbs up to two more bytes, then in_ready
// drops.
// Reset (rst, synchronous) empties the queue and output register, and puts
// the finder back to hunting with an empty title window.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module title_crlf_frame_finder import tcff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        echo_byte,
  output logic              title_hit,
  output logic              in_body,
  output logic              frame_done,
  output logic              overflow,
  output logic [2:0]        msg_type,
  output logic [LEN_W-1:0]  frame_length,
  output logic [7:0]        running_xor
);

  class_beat_t front_beat;
  class_beat_t q_beat;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // classify incoming bytes
  tcff_front u_front (
    .data_byte (data_byte),
    .beat      (front_beat)
  );

  // decoupling queue
  tcff_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (front_beat),
    .full      (q_full),
    .pop       (q_pop),
    .pop_beat  (q_beat),
    .not_empty (q_valid)
  );

  // match, frame tracking and result register
  tcff_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_beat       (q_beat),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .echo_byte    (echo_byte),
    .title_hit    (title_hit),
    .in_body      (in_body),
    .frame_done   (frame_done),
    .overflow     (overflow),
    .msg_type     (msg_type),
    .frame_length (frame_length),
    .running_xor  (running_xor)
  );

  // checks
  `ASSERT_IMPLIES(a_hit_fields, clk, rst, out_valid && title_hit, !in_body && !frame_done && !overflow && msg_type != MSG_NONE)
  `ASSERT_IMPLIES(a_end_in_body, clk, rst, out_valid && (frame_done || overflow), in_body && !(frame_done && overflow))
  `ASSERT_IMPLIES(a_hunt_quiet, clk, rst, out_valid && !title_hit && !in_body, msg_type == MSG_NONE && frame_length == '0 && running_xor == '0)
  `ASSERT_NEXT(a_pop_fills_out, clk, rst, q_pop, out_valid)

endmodule

// File: design/tcff_front.sv
// front end: classifies each incoming byte against the title tables
`timescale 1ns / 1ps

module tcff_front import tcff_pkg::*; (
  input  logic [7:0]  data_byte,
  output class_beat_t beat
);

  // per-title, per-position character compares plus special characters
  always_comb begin
    beat.data      = data_byte;
    beat.is_dollar = (data_byte == CH_DOLLAR);
    beat.is_cr     = (data_byte == CH_CR);
    beat.is_lf     = (data_byte == CH_LF);
    for (int t = 0; t < NUM_TITLES; t++) begin
      for (int p = 0; p < WIN_MAX; p++) begin
        beat.char_match[t][p] = (data_byte == TITLE_TEXT[t][p]);
      end
    end
  end

endmodule

// File: design/tcff_queue.sv
// short queue of classified beats between front and back
`timescale 1ns / 1ps

module tcff_queue import tcff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  class_beat_t push_beat,
  output logic        full,
  input  logic        pop,
  output class_beat_t pop_beat,
  output logic        not_empty
);

  class_beat_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic [QCNT_W-1:0]       count_next;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_beat  = entries[rd_ptr];

  // occupancy update
  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

endmodule

// File: design/tcff_back.sv
// back end: title matching, frame tracking and the output register
`timescale 1ns / 1ps

module tcff_back import tcff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  class_beat_t       q_beat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        echo_byte,
  output logic              title_hit,
  output logic              in_body,
  output logic              frame_done,
  output logic              overflow,
  output logic [2:0]        msg_type,
  output logic [LEN_W-1:0]  frame_length,
  output logic [7:0]        running_xor
);

  // state
  phase_t                  phase;
  phase_t                  phase_next;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       fill_next;
  logic [NUM_TITLES-1:0]   cand;
  logic [NUM_TITLES-1:0]   cand_next;
  logic [7:0]              win_xor;
  logic [7:0]              win_xor_next;
  msg_type_t               kind_held;
  msg_type_t               kind_held_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [7:0]              xor_acc;
  logic [7:0]              xor_acc_next;
  logic                    prior_cr;
  logic                    prior_cr_next;

  // matching terms
  logic                    advance;
  logic [NUM_TITLES-1:0]   survive;
  logic [NUM_TITLES-1:0]   complete;
  logic                    any_hit;
  msg_type_t               hit_kind;
  logic [TLEN_W-1:0]       fill_inc;
  logic [CNT_W-1:0]        count_inc;
  logic [7:0]              xor_body;
  logic                    body_ovf;
  logic                    body_done;

  // result fields
  logic                    r_hit;
  logic                    r_body;
  logic                    r_done;
  logic                    r_ovf;
  msg_type_t               r_kind;
  logic [LEN_W-1:0]        r_len;
  logic [7:0]              r_xor;

  assign advance = q_valid && (!out_valid || out_ready);
  assign q_pop   = advance;

  // candidate titles that still match after this byte
  always_comb begin
    fill_inc = TLEN_W'(fill) + 1'b1;
    for (int t = 0; t < NUM_TITLES; t++) begin
      survive[t]  = cand[t] && (TLEN_W'(fill) < TITLE_LEN[t]) &&
                    q_beat.char_match[t][fill];
      complete[t] = survive[t] && (fill_inc == TITLE_LEN[t]);
    end
    any_hit  = |complete;
    hit_kind = MSG_NONE;
    for (int t = NUM_TITLES - 1; t >= 0; t--) begin
      if (complete[t]) begin
        hit_kind = TITLE_KIND[t];
      end
    end
  end

  // body byte bookkeeping
  always_comb begin
    count_inc = count + 1'b1;
    xor_body  = xor_acc ^ q_beat.data;
    body_ovf  = (count_inc == CNT_W'(MAX_FRAME - 1));
    body_done = !body_ovf && q_beat.is_lf && prior_cr;
  end

  // next phase
  always_comb begin
    case (phase)
      PH_HUNT: phase_next = any_hit ? PH_BODY : PH_HUNT;
      PH_BODY: phase_next = (body_ovf || body_done) ? PH_HUNT : PH_BODY;
      default: phase_next = PH_HUNT;
    endcase
  end

  // next datapath state and result fields
  always_comb begin
    fill_next      = fill;
    cand_next      = cand;
    win_xor_next   = win_xor;
    kind_held_next = kind_held;
    count_next     = count;
    xor_acc_next   = xor_acc;
    prior_cr_next  = prior_cr;
    r_hit          = 1'b0;
    r_body         = 1'b0;
    r_done         = 1'b0;
    r_ovf          = 1'b0;
    r_kind         = MSG_NONE;
    r_len          = '0;
    r_xor          = '0;
    case (phase)
      PH_HUNT: begin
        if (any_hit) begin
          fill_next      = '0;
          cand_next      = '1;
          win_xor_next   = '0;
          kind_held_next = hit_kind;
          count_next     = CNT_W'(fill_inc);
          xor_acc_next   = win_xor ^ q_beat.data;
          prior_cr_next  = q_beat.is_cr;
          r_hit          = 1'b1;
          r_kind         = hit_kind;
          r_len          = LEN_W'(fill_inc);
          r_xor          = win_xor ^ q_beat.data;
        end else if (|survive) begin
          fill_next    = fill_inc[FILL_W-1:0];
          cand_next    = survive;
          win_xor_next = win_xor ^ q_beat.data;
        end else if (q_beat.is_dollar) begin
          // resync onto the new title start
          fill_next    = FILL_W'(1);
          cand_next    = '1;
          win_xor_next = q_beat.data;
        end else begin
          fill_next    = '0;
          cand_next    = '1;
          win_xor_next = '0;
        end
      end
      PH_BODY: begin
        count_next    = count_inc;
        xor_acc_next  = xor_body;
        prior_cr_next = q_beat.is_cr;
        r_body        = 1'b1;
        r_done        = body_done;
        r_ovf         = body_ovf;
        r_kind        = kind_held;
        r_len         = (32'(count_inc) > LEN_SAT) ? LEN_W'(LEN_SAT) : LEN_W'(count_inc);
        r_xor         = xor_body;
        if (body_ovf || body_done) begin
          fill_next      = '0;
          cand_next      = '1;
          win_xor_next   = '0;
          kind_held_next = MSG_NONE;
        end
      end
      default: begin
        fill_next = '0;
      end
    endcase
  end

  // state registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      fill      <= '0;
      cand      <= '1;
      win_xor   <= '0;
      kind_held <= MSG_NONE;
      count     <= '0;
      xor_acc   <= '0;
      prior_cr  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase     <= phase_next;
        fill      <= fill_next;
        cand      <= cand_next;
        win_xor   <= win_xor_next;
        kind_held <= kind_held_next;
        count     <= count_next;
        xor_acc   <= xor_acc_next;
        prior_cr  <= prior_cr_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      echo_byte    <= q_beat.data;
      title_hit    <= r_hit;
      in_body      <= r_body;
      frame_done   <= r_done;
      overflow     <= r_ovf;
      msg_type     <= r_kind;
      frame_length <= r_len;
      running_xor  <= r_xor;
    end
  end

endmodule
